// ===== hdl/bli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_pkg: shared types and constants for the bounded list block
// Sizes, command codes, controller states and the control/status words.
// ----------------------------------------------------------------------------
package bli_pkg;

  localparam int CAPACITY = 32;
  localparam int PW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 30;
  localparam int POS_W    = 10;
  localparam int IDX_W    = 6;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_STREAM
  } bli_state_t;

  typedef struct packed {
    logic load;
    logic ins_front;
    logic ins_back;
    logic set_drop;
    logic del_init;
    logic del_rd;
    logic del_wr;
    logic del_done;
    logic stream;
  } bli_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              pos_ok;
    logic              shift_more;
    logic              stream_last;
  } bli_status_t;

endpackage

// ===== hdl/bounded_list_insert_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_top: bounded ordered list with streamed readout
// Insert at front, append at back or delete at a position, then read out
// the whole list front to back, one word per cycle.
//
//   channel  | handshake              | words
//   ---------+------------------------+---------------------------------------
//   input    | start, busy            | in_func, in_value, in_position
//   result   | out_valid (strobe)     | out_element, out_element_index,
//            |                        | out_last, out_list_empty,
//            |                        | out_insert_dropped
//
// An in-range delete first moves each word behind the position one place
// toward the front, each read in ST_DEL_RD and written back in ST_DEL_WR.
// The list is then read out; an empty list still gives one result word.
// Synchronous reset empties the list.
// The receiver cannot stall; busy holds off the next command.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bli_pkg::FUNC_W-1:0] in_func,
  input  logic [bli_pkg::VAL_W-1:0]  in_value,
  input  logic [bli_pkg::POS_W-1:0]  in_position,
  output logic                       out_valid,
  output logic [bli_pkg::VAL_W-1:0]  out_element,
  output logic [bli_pkg::IDX_W-1:0]  out_element_index,
  output logic                       out_last,
  output logic                       out_list_empty,
  output logic                       out_insert_dropped
);
  import bli_pkg::*;

  bli_cmd_t    cmd;
  bli_status_t status;

  bli_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bli_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_func            (in_func),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_element        (out_element),
    .out_element_index  (out_element_index),
    .out_last           (out_last),
    .out_list_empty     (out_list_empty),
    .out_insert_dropped (out_insert_dropped)
  );

endmodule

// ===== hdl/bli_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_ctrl: command sequencer
// Steps each command through update, delete shift and list readout.
// ----------------------------------------------------------------------------
module bli_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bli_pkg::bli_status_t status,
  output bli_pkg::bli_cmd_t    cmd,
  output logic                 busy
);
  import bli_pkg::*;

  bli_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_STREAM;
        case (status.func) inside
          FUNC_FRONT, FUNC_BACK: begin
            if (status.full) begin
              cmd.set_drop = 1'b1;
            end else if (status.func == FUNC_FRONT) begin
              cmd.ins_front = 1'b1;
            end else begin
              cmd.ins_back = 1'b1;
            end
          end
          FUNC_DEL: begin
            if (status.pos_ok) begin
              cmd.del_init = 1'b1;
              state_nxt    = ST_DEL_RD;
            end
          end
          default: state_nxt = ST_STREAM;
        endcase
      end
      ST_DEL_RD: begin
        if (status.shift_more) begin
          cmd.del_rd = 1'b1;
          state_nxt  = ST_DEL_WR;
        end else begin
          cmd.del_done = 1'b1;
          state_nxt    = ST_STREAM;
        end
      end
      ST_DEL_WR: begin
        cmd.del_wr = 1'b1;
        state_nxt  = ST_DEL_RD;
      end
      ST_STREAM: begin
        cmd.stream = 1'b1;
        if (status.stream_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/bli_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_dp: list storage and datapath
// Circular buffer with head pointer and count, shift unit for delete,
// registered readout of one word per cycle.
// ----------------------------------------------------------------------------
module bli_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bli_pkg::bli_cmd_t            cmd,
  output bli_pkg::bli_status_t         status,
  input  logic [bli_pkg::FUNC_W-1:0]   in_func,
  input  logic [bli_pkg::VAL_W-1:0]    in_value,
  input  logic [bli_pkg::POS_W-1:0]    in_position,
  output logic                         out_valid,
  output logic [bli_pkg::VAL_W-1:0]    out_element,
  output logic [bli_pkg::IDX_W-1:0]    out_element_index,
  output logic                         out_last,
  output logic                         out_list_empty,
  output logic                         out_insert_dropped
);
  import bli_pkg::*;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[PW-1:0];
  endfunction

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rd_data_r;

  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              drop_r, drop_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [VAL_W-1:0]  value_r;
  logic [POS_W-1:0]  pos_r;

  logic              tag_valid_r;
  logic [CW-1:0]     tag_idx_r;
  logic              tag_last_r;
  logic              tag_empty_r;
  logic              tag_drop_r;

  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [PW-1:0]     mem_raddr;
  logic [CW-1:0]     k_inc;
  logic              list_empty;

  assign k_inc      = k_r + CW'(1);
  assign list_empty = (count_r == '0);

  assign status.func        = func_r;
  assign status.full        = (count_r == CW'(CAPACITY));
  assign status.pos_ok      = (pos_r < POS_W'(count_r));
  assign status.shift_more  = ((CW+1)'(k_r) + (CW+1)'(1)) < (CW+1)'(count_r);
  assign status.stream_last = list_empty ||
                              (((CW+1)'(i_r) + (CW+1)'(1)) == (CW+1)'(count_r));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    drop_nxt  = drop_r;
    mem_we    = 1'b0;
    mem_waddr = wrap_add(head_r, k_r);
    mem_wdata = rd_data_r;
    mem_raddr = wrap_add(head_r, i_r);
    if (cmd.load) begin
      drop_nxt = 1'b0;
      i_nxt    = '0;
    end
    if (cmd.set_drop) begin
      drop_nxt = 1'b1;
    end
    if (cmd.ins_front) begin
      head_nxt  = (head_r == '0) ? PW'(CAPACITY - 1) : head_r - PW'(1);
      mem_we    = 1'b1;
      mem_waddr = head_nxt;
      mem_wdata = value_r;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.ins_back) begin
      mem_we    = 1'b1;
      mem_waddr = wrap_add(head_r, count_r);
      mem_wdata = value_r;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.del_init) begin
      k_nxt = CW'(pos_r);
    end
    if (cmd.del_rd) begin
      mem_raddr = wrap_add(head_r, k_inc);
    end
    if (cmd.del_wr) begin
      mem_we = 1'b1;
      k_nxt  = k_inc;
    end
    if (cmd.del_done) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.stream) begin
      i_nxt = i_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      tag_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      tag_valid_r <= cmd.stream;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    drop_r <= drop_nxt;
    if (cmd.load) begin
      func_r  <= in_func;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    tag_idx_r   <= i_r;
    tag_last_r  <= status.stream_last;
    tag_empty_r <= list_empty;
    tag_drop_r  <= drop_r;
  end

  assign out_valid          = tag_valid_r;
  assign out_element        = tag_empty_r ? '0 : rd_data_r;
  assign out_element_index  = tag_empty_r ? '0 : IDX_W'(tag_idx_r);
  assign out_last           = tag_last_r;
  assign out_list_empty     = tag_empty_r;
  assign out_insert_dropped = tag_drop_r;

endmodule
